### rtl/min_perfect_number_scan_defines.svh
// ---------------------------------------------------------------------------
// Minimum perfect number scan: assertion macros
// Shared concurrent assertion forms, clocked on clk and reset by rst_n.
// ---------------------------------------------------------------------------
`ifndef MIN_PERFECT_NUMBER_SCAN_DEFINES_SVH
`define MIN_PERFECT_NUMBER_SCAN_DEFINES_SVH

// same-cycle implication
`define MPNS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpns assertion failed");

// next-cycle implication
`define MPNS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpns assertion failed");

`endif

### rtl/mpns_pkg.sv
// ---------------------------------------------------------------------------
// Minimum perfect number scan: package
// Sequencer states, divider handshake structs and fixed result widths.
// ---------------------------------------------------------------------------
package mpns_pkg;

  localparam int MIN_BITS = 15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_rsp_t;

endpackage

### rtl/mpns_divider.sv
// ---------------------------------------------------------------------------
// Minimum perfect number scan: remainder unit
// Restoring divider, one quotient bit per cycle; reports a zero remainder.
// ---------------------------------------------------------------------------
module mpns_divider #(
  parameter int MAG_W = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mpns_pkg::div_req_t   req,
  input  logic [MAG_W-1:0]     dividend,
  input  logic [MAG_W-1:0]     divisor,
  output mpns_pkg::div_rsp_t   rsp
);
  import mpns_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0] dvd_r, dvd_nxt;
  logic [MAG_W-1:0] dsr_r, dsr_nxt;
  logic [MAG_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic             zero_r, zero_nxt;

  logic [MAG_W:0]   trial;
  logic [MAG_W:0]   diff;
  logic [MAG_W-1:0] rem_step;

  always_comb begin
    trial    = {rem_r, dvd_r[MAG_W-1]};
    diff     = trial - {1'b0, dsr_r};
    rem_step = (trial >= {1'b0, dsr_r}) ? diff[MAG_W-1:0] : trial[MAG_W-1:0];

    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    if (req.start) begin
      dvd_nxt = dividend;
      dsr_nxt = divisor;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(MAG_W);
    end else if (cnt_r != '0) begin
      dvd_nxt = {dvd_r[MAG_W-2:0], 1'b0};
      rem_nxt = rem_step;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        done_nxt = 1'b1;
        zero_nxt = (rem_step == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
    rem_r  <= rem_nxt;
    zero_r <= zero_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.rem_zero = zero_r;

endmodule

### rtl/min_perfect_number_scan.sv
// ---------------------------------------------------------------------------
// Minimum perfect number scan: top level
// Trial-division aliquot sum per element; keeps the smallest perfect value
// and reports it after the element flagged as last.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------
//   in_     | in_valid / in_ready   | in_element, in_last_element
//   out_    | out_valid / out_ready | out_min_perfect, out_found
//
// Each candidate divisor is tested in turn in the shared remainder unit. For a
// positive element v >= 2 the divisors 1 to v-1 are tried; the scan stops
// early once the divisor sum passes v. Other elements skip the remainder unit.
// in_ready is high only while the sequencer is idle. A result waits in the
// output register; the next element is taken meanwhile, and only a further
// last element stalls until that result is transferred.
// Reset: synchronous, active low; clears sequencer, minimum and output valid.
// ---------------------------------------------------------------------------
`include "min_perfect_number_scan_defines.svh"

module min_perfect_number_scan #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_element,
  input  logic                  in_last_element,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [14:0]           out_min_perfect,
  output logic                  out_found
);
  import mpns_pkg::*;

  localparam int MAG_W = VALUE_BITS - 1;
  localparam int EXT_W = (MAG_W > MIN_BITS) ? MAG_W : MIN_BITS;

  st_t                 state_r, state_nxt;
  logic [MAG_W-1:0]    val_r, val_nxt;
  logic                last_r, last_nxt;
  logic [MAG_W-1:0]    d_r, d_nxt;
  logic [MAG_W:0]      sum_r, sum_nxt;
  logic [MIN_BITS-1:0] min_r, min_nxt;
  logic                any_r, any_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MIN_BITS-1:0] out_min_r, out_min_nxt;
  logic                out_found_r, out_found_nxt;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [MAG_W-1:0]    div_dividend;
  logic [MAG_W-1:0]    div_divisor;

  logic [MAG_W-1:0]    mag;
  logic                cand;
  logic [MAG_W:0]      acc;
  logic [MAG_W-1:0]    dinc;
  logic [EXT_W-1:0]    val_ext;
  logic [MIN_BITS-1:0] v15;

  mpns_divider #(
    .MAG_W (MAG_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp)
  );

  always_comb begin
    mag     = in_element[MAG_W-1:0];
    cand    = !in_element[VALUE_BITS-1] && (mag >= MAG_W'(2));
    acc     = div_rsp.rem_zero ? (sum_r + {1'b0, d_r}) : sum_r;
    dinc    = d_r + 1'b1;
    val_ext = EXT_W'(val_r);
    v15     = val_ext[MIN_BITS-1:0];

    state_nxt     = state_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    d_nxt         = d_r;
    sum_nxt       = sum_r;
    min_nxt       = min_r;
    any_nxt       = any_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_min_nxt   = out_min_r;
    out_found_nxt = out_found_r;
    div_req.start = 1'b0;
    div_dividend  = val_r;
    div_divisor   = dinc;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          val_nxt  = mag;
          last_nxt = in_last_element;
          if (cand) begin
            d_nxt         = MAG_W'(1);
            sum_nxt       = '0;
            div_req.start = 1'b1;
            div_dividend  = mag;
            div_divisor   = MAG_W'(1);
            state_nxt     = ST_DIV;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          sum_nxt = acc;
          if (acc > {1'b0, val_r}) begin
            state_nxt = ST_DONE;
          end else if (dinc == val_r) begin
            if (acc == {1'b0, val_r}) begin
              if (!any_r || (v15 < min_r)) begin
                min_nxt = v15;
              end
              any_nxt = 1'b1;
            end
            state_nxt = ST_DONE;
          end else begin
            d_nxt         = dinc;
            div_req.start = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = any_r ? min_r : '0;
          out_found_nxt = any_r;
          min_nxt       = '0;
          any_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_r       <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    last_r      <= last_nxt;
    d_r         <= d_nxt;
    sum_r       <= sum_nxt;
    out_min_r   <= out_min_nxt;
    out_found_r <= out_found_nxt;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_min_perfect = out_min_r;
  assign out_found       = out_found_r;

  `MPNS_ASSERT_SAME(a_done_in_div, div_rsp.done, state_r == ST_DIV)
  `MPNS_ASSERT_SAME(a_sum_bounded, state_r == ST_DIV, sum_r <= {1'b0, val_r})
  `MPNS_ASSERT_SAME(a_min_clear, !any_r, min_r == '0)
  `MPNS_ASSERT_SAME(a_none_zero, out_valid_r && !out_found_r, out_min_r == '0)
  `MPNS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, state_r != ST_IDLE)

endmodule

### bench/min_perfect_number_scan_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Minimum perfect number scan: regression bench
// Streams matrices of signed elements through the scanner in bursts, while
// the result side stalls in its own pattern. A local model of the divisor
// sum predicts the minimum perfect value of each matrix, and every result
// transfer is checked in order against it.
// ---------------------------------------------------------------------------
module min_perfect_number_scan_test;
  import mpns_pkg::*;

  localparam int VALUE_BITS    = 16;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 100;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
    bit                    drain;
  } element_t;

  typedef struct {
    logic [MIN_BITS-1:0] min_value;
    logic                found;
  } scan_result_t;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_element      = '0;
  logic                  in_last_element = 1'b0;
  logic                  out_valid;
  logic                  out_ready       = 1'b0;
  logic [14:0]           out_min_perfect;
  logic                  out_found;

  element_t     element_queue[$];
  scan_result_t minimum_queue[$];

  logic [MIN_BITS-1:0] running_min = '0;
  logic                any_found   = 1'b0;

  element_t     current;
  scan_result_t want_result;
  int           burst_left  = 0;
  int           gap_left    = 0;
  int           stall_phase = 0;
  bit           stall_mode  = 1'b0;

  int errors           = 0;
  int cycles           = 0;
  int elements_sent    = 0;
  int matrices_checked = 0;
  int perfect_seen     = 0;

  min_perfect_number_scan #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_element     (in_element),
    .in_last_element(in_last_element),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_min_perfect(out_min_perfect),
    .out_found      (out_found)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic bit is_perfect_value(input logic [VALUE_BITS-1:0] raw);
    int unsigned v;
    int unsigned sum;
    if (raw[VALUE_BITS-1]) return 1'b0;
    v = 32'(raw);
    if (v < 2) return 1'b0;
    sum = 0;
    for (int unsigned d = 1; d < v; d++) begin
      if (v % d == 0) begin
        sum += d;
        if (sum > v) return 1'b0;
      end
    end
    return sum == v;
  endfunction

  task automatic absorb_element(input element_t e);
    scan_result_t r;
    logic [MIN_BITS-1:0] v;
    if (is_perfect_value(e.value)) begin
      v = e.value[MIN_BITS-1:0];
      perfect_seen++;
      if (!any_found || v < running_min) running_min = v;
      any_found = 1'b1;
    end
    if (e.last) begin
      r.min_value = any_found ? running_min : '0;
      r.found     = any_found;
      minimum_queue.push_back(r);
      running_min = '0;
      any_found   = 1'b0;
    end
  endtask

  task automatic add_element(input logic [VALUE_BITS-1:0] value, input bit last,
                             input bit drain);
    element_t e;
    e.value = value;
    e.last  = last;
    e.drain = drain;
    element_queue.push_back(e);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_element(current);
        elements_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (element_queue.size() > 0 &&
                     (!element_queue[0].drain || minimum_queue.size() == 0)) begin
          current = element_queue.pop_front();
          in_valid        <= 1'b1;
          in_element      <= current.value;
          in_last_element <= current.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (minimum_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result min_perfect=%0d found=%0b",
                                    out_min_perfect, out_found));
        end else begin
          want_result = minimum_queue.pop_front();
          matrices_checked++;
          if (out_min_perfect !== want_result.min_value)
            report_mismatch($sformatf("min_perfect %0d, want %0d",
                                      out_min_perfect, want_result.min_value));
          if (out_found !== want_result.found)
            report_mismatch($sformatf("found %0b, want %0b",
                                      out_found, want_result.found));
        end
      end
      if (stall_phase == 0) begin
        stall_mode  = ~stall_mode;
        stall_phase = $urandom_range(8, 80);
      end else begin
        stall_phase--;
      end
      out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, minimum_queue.size());
      $display("min_perfect_number_scan regression: fail");
      $finish;
    end
  end

  initial begin
    int random_count;
    int len;
    int pick;
    bit drain;
    logic [VALUE_BITS-1:0] value;

    // single perfect element
    add_element(16'd6, 1'b1, 1'b0);
    // minimum over several perfect values
    add_element(16'd28, 1'b0, 1'b0);
    add_element(16'd6, 1'b0, 1'b0);
    add_element(16'd496, 1'b1, 1'b0);
    // nothing perfect: zero, minus one, one, two
    add_element(16'd0, 1'b0, 1'b0);
    add_element(16'hFFFF, 1'b0, 1'b0);
    add_element(16'd1, 1'b0, 1'b0);
    add_element(16'd2, 1'b1, 1'b0);
    // field extremes, then the largest perfect value that fits
    add_element(16'h8000, 1'b0, 1'b1);
    add_element(16'h7FFF, 1'b0, 1'b0);
    add_element(16'd8128, 1'b1, 1'b0);
    // later, smaller perfect value replaces the minimum
    add_element(16'd496, 1'b0, 1'b0);
    add_element(16'd28, 1'b1, 1'b0);
    // abundant value stops early
    add_element(16'd12, 1'b0, 1'b0);
    add_element(16'd1, 1'b1, 1'b0);
    // negated perfect values are not perfect
    add_element(16'd8128, 1'b0, 1'b0);
    add_element(16'hE040, 1'b0, 1'b0);
    add_element(16'd6, 1'b1, 1'b0);
    add_element(16'hFFFA, 1'b1, 1'b1);

    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      len   = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
      drain = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      value = VALUE_BITS'($urandom_range(1, 40));
        else if (pick < 55) value = $urandom_range(0, 1) ? 16'd6 : 16'd28;
        else if (pick < 59) value = 16'd496;
        else if (pick < 84) value = VALUE_BITS'($urandom_range(16'h8000, 16'hFFFF));
        else if (pick < 92) value = 16'd0;
        else                value = VALUE_BITS'($urandom_range(41, 300));
        add_element(value, i == len - 1, drain && i == 0);
        random_count++;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (element_queue.size() > 0 || in_valid || minimum_queue.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("sent %0d elements holding %0d perfect values; checked %0d matrix results",
             elements_sent, perfect_seen, matrices_checked);
    $display("covered field extremes, negatives, zero and all perfect values below 2^15");
    if (errors == 0 && minimum_queue.size() == 0) begin
      $display("min_perfect_number_scan regression: pass");
    end else begin
      $display("min_perfect_number_scan regression: fail");
    end
    $finish;
  end

endmodule
